// ===== design/sibd_pkg.sv =====
// shared types and constants for the descending score sorter
package sibd_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_W     = 24;
    localparam int SCORE_W  = 32;
    localparam int RANK_W   = 6;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 64;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '0;

    // command word broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic shift;
    } ctl_t;

endpackage

// ===== design/sibd_cell.sv =====
// one insertion cell of the sorting chain
module sibd_cell
    import sibd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic [ID_W-1:0]    new_id,
    input  logic [SCORE_W-1:0] new_score,
    input  entry_t             prev_ent,
    input  logic               prev_ins,
    input  entry_t             next_ent,
    output entry_t             ent,
    output logic               ins
);

    logic               valid_reg;
    logic [ID_W-1:0]    id_reg;
    logic [SCORE_W-1:0] score_reg;
    entry_t             ent_next;

    // new word goes in front of any strictly lower score, keeps ties stable
    assign ins = !valid_reg || (new_score > score_reg);
    assign ent = {valid_reg, id_reg, score_reg};

    always_comb
    begin
        ent_next = ent;
        if (ctl.shift)
        begin
            ent_next = next_ent;
        end
        else if (ctl.load && ins)
        begin
            if (prev_ins)
            begin
                ent_next = prev_ent;
            end
            else
            begin
                ent_next.valid = 1'b1;
                ent_next.id    = new_id;
                ent_next.score = new_score;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ent_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= ent_next.id;
        score_reg <= ent_next.score;
    end

endmodule

// ===== design/sort_items_by_score_desc.sv =====
// top level of the stable descending score sorter
//
// input stream (s_*): one word per item, id and 16.16 score in s_tdata,
// s_tlast closes the batch. words are taken one per cycle while loading.
// each word is dropped into a chain of CAPACITY insertion cells, so the
// chain always holds the batch sorted by score, highest first, ties in
// arrival order. words beyond CAPACITY are discarded and flagged.
// output stream (m_*): after the closing word the chain drains from its
// head, one word per cycle while m_tready is high: id, score and rank in
// m_tdata, m_tlast on the final word, m_tuser set on every word of a batch
// that lost items. first result appears in the cycle after the closing word is taken.
// s_tready is low for the whole drain, since the chain shifts towards its
// head then. a stalled receiver simply freezes the chain, the head word
// holds. reset empties the chain (valid bits only) and returns to loading.
module sort_items_by_score_desc
    import sibd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // item_id[23:0], item_score[55:24]
    input  logic             s_tlast,   // batch_last
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // out_id[23:0], out_score[55:24], out_rank[61:56], zero
    output logic             m_tlast,   // out_last
    output logic             m_tuser    // overflow
);

    entry_t ent [CAPACITY];
    logic   ins [CAPACITY];
    ctl_t   ctl;

    logic              draining_reg, draining_next;
    logic              dropped_reg, dropped_next;
    logic [RANK_W-1:0] rank_reg, rank_next;

    logic s_acc, m_acc, full;

    assign s_tready = !draining_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign full     = ent[CAPACITY-1].valid;

    // head of the chain is the output register
    assign m_tvalid = draining_reg && ent[0].valid;
    assign m_acc    = m_tvalid && m_tready;
    assign m_tlast  = !ent[1].valid;
    assign m_tuser  = dropped_reg;
    assign m_tdata  = {2'b00, rank_reg, ent[0].score, ent[0].id};

    assign ctl.load  = s_acc && !full;
    assign ctl.shift = m_acc;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t prev_ent;
            logic   prev_ins;
            entry_t next_ent;

            if (i == 0)
            begin : g_head
                assign prev_ent = ENTRY_EMPTY;
                assign prev_ins = 1'b0;
            end
            else
            begin : g_body
                assign prev_ent = ent[i-1];
                assign prev_ins = ins[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_tail
                assign next_ent = ENTRY_EMPTY;
            end
            else
            begin : g_inner
                assign next_ent = ent[i+1];
            end

            sibd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .new_id    (s_tdata[ID_W-1:0]),
                .new_score (s_tdata[ID_W+SCORE_W-1:ID_W]),
                .prev_ent  (prev_ent),
                .prev_ins  (prev_ins),
                .next_ent  (next_ent),
                .ent       (ent[i]),
                .ins       (ins[i])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        rank_next     = rank_reg;
        if (s_acc)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (s_tlast)
            begin
                draining_next = 1'b1;
            end
        end
        if (m_acc)
        begin
            rank_next = rank_reg + 1'b1;
            if (m_tlast)
            begin
                draining_next = 1'b0;
                dropped_next  = 1'b0;
                rank_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
            rank_reg     <= '0;
        end
        else
        begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
            rank_reg     <= rank_next;
        end
    end

    // loading and draining never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while chain drains");

    // closing word starts the drain on the next cycle
    a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after closing word");

    // each drain starts at rank zero
    a_rank_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (rank_reg == '0))
        else $error("drain did not start at rank zero");

    // after the final word the chain is empty and loading resumes
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !ent[0].valid))
        else $error("chain not empty after final word");

endmodule
